// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker modules of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spf_pkg.sv =====
// Package of the smallest prime factor factorizer: field widths, status codes,
// controller states and default sizes. Used by the top level and the checker.
package spf_pkg;

  localparam int VALUE_W        = 17;
  localparam int STATUS_W       = 2;
  localparam int TABLE_SIZE_DEF = 131072;
  localparam int MAX_RESULTS    = 16;
  localparam int COUNT_W        = $clog2(MAX_RESULTS);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NONE  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_PCHK,
    ST_PWAIT,
    ST_MRD,
    ST_MWR,
    ST_IDLE,
    ST_LOOK,
    ST_LWAIT,
    ST_DIV,
    ST_EMIT
  } fsm_e;

endpackage

// ===== hdl/spf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module spf_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/spf_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing; used by the factorizer top level.
module spf_div #(
  parameter int W = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    trial   = shifted - {1'b0, div_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[W]) begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/smallest_prime_factor_factorizer_top.sv =====
// Top level of the smallest prime factor factorizer: sieve fill and factorizing controller.
// Depends on spf_pkg, spf_ram and spf_div.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------
//   input    | in_valid_i / in_ready_o  | value_i
//   output   | out_valid_o / out_ready_i| factor_o, last_o, status_o
//
// After reset the table is written once, entry by entry, then sieved over odd multiples
// of odd primes, each visited entry read and, if still unmarked, written; no request is
// taken until then. Each prime factor passes through a table read, a wait for its data,
// the 17-step radix-2 divider and an emit; a special value goes from the request straight
// to its emit, and every emit waits while out_ready_i is low.
// A finished result waits in the output register while the next request is taken.
module smallest_prime_factor_factorizer_top #(
  parameter int TABLE_SIZE = spf_pkg::TABLE_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [spf_pkg::VALUE_W-1:0]  value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [spf_pkg::VALUE_W-1:0]  factor_o,
  output logic                         last_o,
  output logic [spf_pkg::STATUS_W-1:0] status_o
);

  import spf_pkg::*;

  localparam int          AW         = $clog2(TABLE_SIZE);
  localparam int          SW         = AW + 2;
  localparam logic [31:0] TableSizeW = 32'(TABLE_SIZE);

  fsm_e state_q, state_d;

  logic [AW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      prm_q, prm_d;
  logic [SW-1:0]      sq_q, sq_d;
  logic [SW-1:0]      mul_q, mul_d;
  logic [VALUE_W-1:0] x_q, x_d;
  logic [COUNT_W-1:0] n_q, n_d;
  logic [VALUE_W-1:0] res_factor_q, res_factor_d;
  logic               res_last_q, res_last_d;
  status_e            res_status_q, res_status_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] factor_q, factor_d;
  logic               last_q, last_d;
  status_e            status_q, status_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [AW-1:0]      ram_wdata, ram_rdata;
  logic               div_start, div_done;
  logic [VALUE_W-1:0] div_quo;
  logic [VALUE_W-1:0] p_now;

  logic in_acc, out_free, cnt_last, sq_done, mul_done, is_prime, is_unmarked;
  logic val_range, val_one;

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cnt_last    = cnt_q == AW'(TABLE_SIZE - 1);
  assign sq_done     = sq_q >= SW'(TABLE_SIZE);
  assign mul_done    = mul_q >= SW'(TABLE_SIZE);
  assign is_prime    = ram_rdata == prm_q;
  assign is_unmarked = ram_rdata == mul_q[AW-1:0];
  assign val_range   = (value_i == '0) || (32'(value_i) >= TableSizeW);
  assign val_one     = value_i == VALUE_W'(1);
  assign p_now       = (ram_rdata < AW'(2)) ? x_q : VALUE_W'(ram_rdata);

  spf_ram #(
    .WIDTH (AW),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spf_div #(
    .W (VALUE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x_q),
    .divisor_i  (p_now),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:  if (cnt_last) state_d = ST_PCHK;
      ST_PCHK:  state_d = sq_done ? ST_IDLE : ST_PWAIT;
      ST_PWAIT: state_d = is_prime ? ST_MRD : ST_PCHK;
      ST_MRD:   state_d = mul_done ? ST_PCHK : ST_MWR;
      ST_MWR:   state_d = ST_MRD;
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (val_range || val_one) ? ST_EMIT : ST_LOOK;
        end
      end
      ST_LOOK:  state_d = ST_LWAIT;
      ST_LWAIT: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = res_last_q ? ST_IDLE : ST_LOOK;
        end
      end
      default:  state_d = ST_INIT;
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = cnt_q;
    ram_wdata  = (!cnt_q[0] && (cnt_q >= AW'(4))) ? AW'(2) : cnt_q;
    ram_raddr  = prm_q;
    div_start  = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT:  ram_we = 1'b1;
      ST_MRD:   ram_raddr = mul_q[AW-1:0];
      ST_MWR: begin
        ram_we    = is_unmarked;
        ram_waddr = mul_q[AW-1:0];
        ram_wdata = prm_q;
      end
      ST_IDLE:  in_ready_o = 1'b1;
      ST_LOOK:  ram_raddr = AW'(x_q);
      ST_LWAIT: div_start = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d        = cnt_q;
    prm_d        = prm_q;
    sq_d         = sq_q;
    mul_d        = mul_q;
    x_d          = x_q;
    n_d          = n_q;
    res_factor_d = res_factor_q;
    res_last_d   = res_last_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    factor_d     = factor_q;
    last_d       = last_q;
    status_d     = status_q;
    unique case (state_q)
      ST_INIT: begin
        cnt_d = cnt_q + AW'(1);
        prm_d = AW'(3);
        sq_d  = SW'(9);
      end
      ST_PWAIT: begin
        if (is_prime) begin
          mul_d = sq_q;
        end else begin
          prm_d = prm_q + AW'(2);
          sq_d  = sq_q + {prm_q, 2'b00} + SW'(4);
        end
      end
      ST_MRD: begin
        if (mul_done) begin
          prm_d = prm_q + AW'(2);
          sq_d  = sq_q + {prm_q, 2'b00} + SW'(4);
        end
      end
      ST_MWR:  mul_d = mul_q + SW'({prm_q, 1'b0});
      ST_IDLE: begin
        if (in_acc) begin
          x_d          = value_i;
          n_d          = '0;
          res_factor_d = '0;
          res_last_d   = 1'b1;
          res_status_d = val_range ? STATUS_RANGE : STATUS_NONE;
        end
      end
      ST_LWAIT: res_factor_d = p_now;
      ST_DIV: begin
        if (div_done) begin
          x_d          = div_quo;
          res_last_d   = (div_quo == VALUE_W'(1)) || (n_q == COUNT_W'(MAX_RESULTS - 1));
          res_status_d = STATUS_OK;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          factor_d    = res_factor_q;
          last_d      = res_last_q;
          status_d    = res_status_q;
          n_d         = n_q + COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      prm_q       <= '0;
      sq_q        <= '0;
      mul_q       <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      prm_q       <= prm_d;
      sq_q        <= sq_d;
      mul_q       <= mul_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    res_factor_q <= res_factor_d;
    res_last_q   <= res_last_d;
    res_status_q <= res_status_d;
    factor_q     <= factor_d;
    last_q       <= last_d;
    status_q     <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule

// ===== hdl/spf_checker.sv =====
// Port-level checker for the smallest prime factor factorizer, bound to its top level.
// Depends on spf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [spf_pkg::VALUE_W-1:0]  factor_o,
  input logic                         last_o,
  input logic [spf_pkg::STATUS_W-1:0] status_o
);

  import spf_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(factor_o) && $stable(last_o) && $stable(status_o),
    "stalled result changed")

  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o,
    !in_ready_o, "request taken while another is in work")

  `ASSERT_ALWAYS(a_special_single, clk_i, rst_ni,
    !out_valid_o || status_o == STATUS_OK || (last_o && factor_o == '0),
    "special status result must be a single zero result")

  `ASSERT_ALWAYS(a_factor_prime_size, clk_i, rst_ni,
    !out_valid_o || status_o != STATUS_OK || factor_o >= VALUE_W'(2),
    "ok result carries a factor below two")

endmodule

bind smallest_prime_factor_factorizer_top spf_checker u_spf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .factor_o    (factor_o),
  .last_o      (last_o),
  .status_o    (status_o)
);
